FILE: sv/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, constants and helpers of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package rfp_pkg;

  // largest RTP packet the build supports, header included
  localparam int MAX_PACKET_LIMIT = 1500;
  localparam int MIN_PACKET_LIMIT = 15;
  localparam int LIMIT_W          = $clog2(MAX_PACKET_LIMIT + 1);
  localparam int CFG_LIMIT_W      = 11;
  localparam int WIDE_W           = 17;

  localparam int RTP_HDR_BYTES = 12;
  localparam int FU_HDR_BYTES  = 2;
  localparam int SC_LEN        = 4;
  localparam int MIN_NAL_LEN   = 5;
  localparam int STEP_W        = $clog2(RTP_HDR_BYTES + FU_HDR_BYTES + 1);
  localparam int POS_W         = $clog2(SC_LEN + 2);

  localparam logic [7:0] SC_LAST_BYTE = 8'h01;
  localparam logic [7:0] RTP_V2_BYTE  = 8'h80;
  localparam logic [7:0] NRI_MASK     = 8'he0;
  localparam logic [7:0] TYPE_MASK    = 8'h1f;
  localparam logic [7:0] FU_A_TYPE    = 8'd28;

  // configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SSRC     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PT       = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_PKT  = 2'd2;

  localparam logic [31:0]            SSRC_RESET    = 32'd0;
  localparam logic [6:0]             PT_RESET      = 7'd96;
  localparam logic [CFG_LIMIT_W-1:0] MAX_PKT_RESET = 11'd1400;

  // command queue depth between front and back
  localparam int QDEPTH = 2;

  typedef logic [LIMIT_W-1:0] limit_t;

  // one result-causing input item, as classified by the front
  typedef struct packed {
    logic        rej;     // rejection, no byte
    logic        hdr;     // rtp header precedes this payload byte
    logic        fu;      // fu indicator and header follow the rtp header
    logic        mark;    // rtp marker bit
    logic        fin;     // last byte of the packet
    logic [7:0]  data;    // payload byte
    logic [15:0] seq;     // rtp sequence number
    logic [31:0] stamp;   // rtp timestamp
    logic [7:0]  fu_ind;  // fu indicator byte
    logic [7:0]  fu_hdr;  // fu header byte
  } cmd_t;

  // saturate the size register into the supported range
  function automatic limit_t clamp_limit(input logic [CFG_LIMIT_W-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    if (w < WIDE_W'(MIN_PACKET_LIMIT)) w = WIDE_W'(MIN_PACKET_LIMIT);
    if (w > WIDE_W'(MAX_PACKET_LIMIT)) w = WIDE_W'(MAX_PACKET_LIMIT);
    return LIMIT_W'(w);
  endfunction

endpackage

FILE: sv/rfp_front.sv
// ----------------------------------------------------------------------------
// rfp_front
// Accepts NAL bytes, checks start code and length, tracks packet and
// fragment position and queues one command for each result-causing byte.
// ----------------------------------------------------------------------------
module rfp_front import rfp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,          // input transaction this cycle
  input  logic [79:0]            in_data,
  input  logic                   in_first,
  input  logic [CFG_LIMIT_W-1:0] max_packet_bytes,
  output logic                   push,
  output cmd_t                   cmd
);

  logic [7:0]  nal_byte;
  logic [31:0] nal_length;
  logic [31:0] frame_time;
  logic        frame_end;

  assign nal_byte   = in_data[7:0];
  assign nal_length = in_data[39:8];
  assign frame_time = in_data[71:40];
  assign frame_end  = in_data[72];

  // state
  logic [31:0]      left, left_next;       // bytes of the nal not yet taken
  logic [POS_W-1:0] pos, pos_next;         // saturating byte position
  limit_t           fill, fill_next;
  logic             fm, fm_next;
  logic             ff, ff_next;
  logic [7:0]       hcopy, hcopy_next;
  logic [31:0]      stamp, stamp_next;
  logic             fend, fend_next;
  logic             drop, drop_next;
  limit_t           limit, limit_next;
  logic [15:0]      seq, seq_next;

  // state as seen by this byte (a first byte restarts the nal)
  logic [31:0]      e_left;
  logic [POS_W-1:0] e_pos;
  limit_t           e_fill;
  logic             e_fm, e_ff, e_fend, e_drop;
  logic [31:0]      e_stamp;
  limit_t           e_limit;
  logic             short_nal;

  always_comb begin
    e_left    = left;
    e_pos     = pos;
    e_fill    = fill;
    e_fm      = fm;
    e_ff      = ff;
    e_stamp   = stamp;
    e_fend    = fend;
    e_drop    = drop;
    e_limit   = limit;
    short_nal = 1'b0;
    if (in_first) begin
      e_left    = nal_length;
      e_pos     = '0;
      e_fill    = '0;
      e_fm      = 1'b0;
      e_ff      = 1'b0;
      e_stamp   = frame_time;
      e_fend    = frame_end;
      e_drop    = 1'b0;
      e_limit   = clamp_limit(max_packet_bytes);
      short_nal = nal_length < 32'(MIN_NAL_LEN);
    end
  end

  // payload arithmetic
  limit_t         cap;
  logic           last;
  logic           fin;
  logic           frag;
  logic [LIMIT_W:0] fill_inc;

  always_comb begin
    cap = e_limit - limit_t'(RTP_HDR_BYTES) - (e_fm ? limit_t'(FU_HDR_BYTES) : '0);
    last = e_left <= 32'(cap);
    fill_inc = {1'b0, e_fill} + 1'b1;
    fin = (fill_inc >= {1'b0, cap}) || (e_left == 32'd1);
    // at the start-code end, e_left = total - 3; payload + header = e_left + 11
    frag = ({1'b0, e_left} + 33'(RTP_HDR_BYTES - 1)) > 33'(e_limit);
  end

  // next state and command
  always_comb begin
    left_next  = left;
    pos_next   = pos;
    fill_next  = fill;
    fm_next    = fm;
    ff_next    = ff;
    hcopy_next = hcopy;
    stamp_next = stamp;
    fend_next  = fend;
    drop_next  = drop;
    limit_next = limit;
    seq_next   = seq;
    push       = 1'b0;
    cmd        = '0;
    cmd.data   = nal_byte;
    cmd.stamp  = e_stamp;
    cmd.seq    = seq;
    if (acc) begin
      left_next  = e_left;
      pos_next   = e_pos;
      fill_next  = e_fill;
      fm_next    = e_fm;
      ff_next    = e_ff;
      stamp_next = e_stamp;
      fend_next  = e_fend;
      drop_next  = e_drop;
      limit_next = e_limit;
      if (in_first) hcopy_next = '0;
      if (short_nal) begin
        drop_next = 1'b1;
        push      = 1'b1;
        cmd.rej   = 1'b1;
        cmd.data  = '0;
      end else if (!e_drop && e_left != '0) begin
        left_next = e_left - 32'd1;
        if (e_pos <= POS_W'(SC_LEN)) pos_next = e_pos + 1'b1;
        if (e_pos < POS_W'(SC_LEN - 1)) begin
          // leading zero bytes of the start code
          if (nal_byte != '0) begin
            drop_next = 1'b1;
            push      = 1'b1;
            cmd.rej   = 1'b1;
            cmd.data  = '0;
          end
        end else if (e_pos == POS_W'(SC_LEN - 1)) begin
          if (nal_byte != SC_LAST_BYTE) begin
            drop_next = 1'b1;
            push      = 1'b1;
            cmd.rej   = 1'b1;
            cmd.data  = '0;
          end else begin
            fm_next = frag;
            ff_next = frag;
          end
        end else begin
          if (e_pos == POS_W'(SC_LEN)) hcopy_next = nal_byte;
          // the nal header byte is folded into fu bytes in fragment mode
          if (!(e_pos == POS_W'(SC_LEN) && e_fm)) begin
            push    = 1'b1;
            cmd.fin = fin;
            if (e_fill == '0) begin
              seq_next   = seq + 16'd1;
              cmd.seq    = seq + 16'd1;
              cmd.hdr    = 1'b1;
              cmd.fu     = e_fm;
              cmd.mark   = e_fend && last;
              cmd.fu_ind = (hcopy & NRI_MASK) | FU_A_TYPE;
              cmd.fu_hdr = {e_ff, last, 6'b0} | (hcopy & TYPE_MASK);
              ff_next    = 1'b0;
            end
            fill_next = fin ? '0 : LIMIT_W'(fill_inc);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left  <= '0;
      pos   <= '0;
      fill  <= '0;
      fm    <= 1'b0;
      ff    <= 1'b0;
      hcopy <= '0;
      stamp <= '0;
      fend  <= 1'b0;
      drop  <= 1'b0;
      limit <= clamp_limit(MAX_PKT_RESET);
      seq   <= '0;
    end else begin
      left  <= left_next;
      pos   <= pos_next;
      fill  <= fill_next;
      fm    <= fm_next;
      ff    <= ff_next;
      hcopy <= hcopy_next;
      stamp <= stamp_next;
      fend  <= fend_next;
      drop  <= drop_next;
      limit <= limit_next;
      seq   <= seq_next;
    end
  end

endmodule

FILE: sv/rfp_queue.sv
// ----------------------------------------------------------------------------
// rfp_queue
// Short command queue that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module rfp_queue import rfp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head,
  output logic head_valid,
  output logic full
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head       = mem[rd_ptr];
  assign head_valid = count != '0;
  assign full       = count == CNT_W'(QDEPTH);

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_cmd;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

FILE: sv/rfp_back.sv
// ----------------------------------------------------------------------------
// rfp_back
// Expands each queued command into RTP header and FU bytes, if flagged, and
// the payload byte, one per cycle unless stalled, via a registered output.
// ----------------------------------------------------------------------------
module rfp_back import rfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_pop,
  input  logic [31:0] stream_source_id,
  input  logic [6:0]  payload_kind,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  output logic [1:0]  m_tuser
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] hdr_len;
  logic              load;
  logic              at_payload;
  logic [7:0]        sel;

  assign hdr_len = !cmd.hdr ? '0 :
                   cmd.fu   ? STEP_W'(RTP_HDR_BYTES + FU_HDR_BYTES) :
                              STEP_W'(RTP_HDR_BYTES);
  assign load       = cmd_valid && (!m_tvalid || m_tready);
  assign at_payload = step == hdr_len;
  assign cmd_pop    = load && at_payload;

  // byte for the current step
  always_comb begin
    if (at_payload) begin
      sel = cmd.data;
    end else begin
      case (step)
        4'd0:    sel = RTP_V2_BYTE;
        4'd1:    sel = {cmd.mark, payload_kind};
        4'd2:    sel = cmd.seq[15:8];
        4'd3:    sel = cmd.seq[7:0];
        4'd4:    sel = cmd.stamp[31:24];
        4'd5:    sel = cmd.stamp[23:16];
        4'd6:    sel = cmd.stamp[15:8];
        4'd7:    sel = cmd.stamp[7:0];
        4'd8:    sel = stream_source_id[31:24];
        4'd9:    sel = stream_source_id[23:16];
        4'd10:   sel = stream_source_id[15:8];
        4'd11:   sel = stream_source_id[7:0];
        4'd12:   sel = cmd.fu_ind;
        4'd13:   sel = cmd.fu_hdr;
        default: sel = cmd.data;
      endcase
    end
  end

  // output register and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      step     <= '0;
    end else if (load) begin
      m_tvalid <= 1'b1;
      step     <= at_payload ? '0 : step + 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sel;
      m_tlast <= at_payload && cmd.fin;
      m_tuser <= {at_payload && cmd.rej, (step == '0) && cmd.hdr};
    end
  end

`ifndef ASSERT_OFF
  // a rejection carries no byte and no packet framing
  a_rej_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> !m_tuser[0] && !m_tlast && m_tdata == '0)
    else $error("rejection result carries packet data");

  // every packet opens with the version byte
  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == RTP_V2_BYTE)
    else $error("packet start without version byte");

  // the step counter stays within one header plus payload
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    cmd_valid |-> step <= hdr_len)
    else $error("header step ran past payload");
`endif

endmodule

FILE: sv/h264_rtp_fu_a_packetizer.sv
// ----------------------------------------------------------------------------
// h264_rtp_fu_a_packetizer
// H.264 NAL byte stream to RTP packet byte stream, single NAL and FU-A modes.
// ----------------------------------------------------------------------------
// One NAL byte is taken per cycle while the queue has room; payload bytes
// leave at one per cycle while the output is ready. Each packet's first
// payload byte follows its 12 RTP header bytes, plus indicator and FU header
// in FU-A mode, while the input keeps flowing into a two-entry command queue
// until it fills. Start-code bytes and the FU-A NAL header byte give no
// output. A bad start code or a NAL shorter than 5 bytes gives one result
// with tuser[1] set and no packet byte. The size limit latches at NAL start.
module h264_rtp_fu_a_packetizer import rfp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [79:0]           s_tdata,   // nal_byte, nal_length, frame_time,
                                           // frame_end, zero fill
  input  logic                  s_tuser,   // nal_first
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // packet_byte
  output logic                  m_tlast,   // packet_final
  output logic [1:0]            m_tuser,   // packet_start, nal_rejected
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]           cfg_wdata
);

  logic [31:0]            stream_source_id;
  logic [6:0]             payload_kind;
  logic [CFG_LIMIT_W-1:0] max_packet_bytes;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stream_source_id <= SSRC_RESET;
      payload_kind     <= PT_RESET;
      max_packet_bytes <= MAX_PKT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SSRC:    stream_source_id <= cfg_wdata;
        CFG_PT:      payload_kind     <= cfg_wdata[6:0];
        CFG_MAX_PKT: max_packet_bytes <= cfg_wdata[CFG_LIMIT_W-1:0];
        default:     ;
      endcase
    end
  end

  logic acc;
  logic push;
  cmd_t push_cmd;
  logic pop;
  cmd_t head;
  logic head_valid;
  logic full;

  assign s_tready = !full;
  assign acc      = s_tvalid && s_tready;

  rfp_front u_front (
    .clk              (clk),
    .rst              (rst),
    .acc              (acc),
    .in_data          (s_tdata),
    .in_first         (s_tuser),
    .max_packet_bytes (max_packet_bytes),
    .push             (push),
    .cmd              (push_cmd)
  );

  rfp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (full)
  );

  rfp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .cmd              (head),
    .cmd_valid        (head_valid),
    .cmd_pop          (pop),
    .stream_source_id (stream_source_id),
    .payload_kind     (payload_kind),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata),
    .m_tlast          (m_tlast),
    .m_tuser          (m_tuser)
  );

endmodule
